// ===== rtl/pdes_pkg.sv =====
package pdes_pkg;

	localparam int WORD_W = 16;
	localparam int IDX_W  = 4;

	localparam logic [WORD_W-1:0] EVENT_ENABLE_RST = 16'hFCFF;
	localparam logic [WORD_W-1:0] INIT_REPORT_RST  = 16'hCC00;

	// Configuration register indexes.
	localparam logic CFG_EVENT_ENABLE = 1'b0;
	localparam logic CFG_INIT_REPORT  = 1'b1;

	// Input mode codes.
	localparam logic MODE_INIT = 1'b0;
	localparam logic MODE_SCAN = 1'b1;

	typedef enum logic [1:0] {
		KIND_PORT   = 2'd0,
		KIND_DOOR   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// Broadcast control for the per-bit debounce lanes.
	typedef struct packed {
		logic prime;
		logic shift;
		logic commit;
	} lane_ctl_t;

	// One input word's worth of pending results and the state snapshot they carry.
	typedef struct packed {
		logic [WORD_W-1:0] ev_mask;
		logic [WORD_W-1:0] act;
		logic              door_ev;
		logic              door_act;
		logic [WORD_W-1:0] stable_port;
		logic              stable_door;
		logic              knob_closed;
	} job_t;

endpackage

// ===== rtl/pdes_lane.sv =====
module pdes_lane #(
	parameter int AGREE_SAMPLES = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdes_pkg::lane_ctl_t ctl,
	input  logic                sample,
	output logic                agree,
	output logic                stable
);
	import pdes_pkg::*;

	localparam int HW = AGREE_SAMPLES - 1;

	// Only the newest AGREE_SAMPLES-1 samples matter; the oldest drops out on the shift.
	logic [HW-1:0] hist_q;
	logic          stable_q;

	always_comb begin
		agree = 1'b1;
		for (int i = 0; i < HW; i++) begin
			if (hist_q[i] != sample) begin
				agree = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '0;
			stable_q <= 1'b0;
		end else if (ctl.prime) begin
			hist_q   <= {HW{sample}};
			stable_q <= sample;
		end else if (ctl.shift) begin
			hist_q <= HW'({hist_q, sample});
			if (ctl.commit) begin
				stable_q <= sample;
			end
		end
	end

	assign stable = stable_q;

endmodule

// ===== rtl/pdes_merge.sv =====
module pdes_merge #(
	parameter int PORT_BITS     = 16,
	parameter int AGREE_SAMPLES = 3
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [pdes_pkg::WORD_W-1:0]             cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    mode,
	input  logic [pdes_pkg::WORD_W-1:0]             port_word,
	input  logic                                    door_level,
	input  logic                                    knob_level,
	output pdes_pkg::lane_ctl_t                     lane_ctl,
	input  logic [((PORT_BITS < pdes_pkg::WORD_W) ? PORT_BITS : pdes_pkg::WORD_W)-1:0] lane_agree,
	input  logic [((PORT_BITS < pdes_pkg::WORD_W) ? PORT_BITS : pdes_pkg::WORD_W)-1:0] lane_stable,
	output logic                                    job_valid,
	output pdes_pkg::job_t                          job,
	input  logic                                    job_take
);
	import pdes_pkg::*;

	localparam int LANES = (PORT_BITS < WORD_W) ? PORT_BITS : WORD_W;
	localparam int HW    = AGREE_SAMPLES - 1;

	logic [WORD_W-1:0] enable_q;
	logic [WORD_W-1:0] report_q;
	logic              scan_en_q;
	logic [HW-1:0]     door_hist_q;
	logic [HW-1:0]     knob_hist_q;
	logic              door_stable_q;
	logic              knob_flag_q;
	logic              job_valid_s1;
	job_t              job_s1;
	job_t              job_next;

	logic [LANES-1:0]  pw_l;
	logic [WORD_W-1:0] pw_w;
	logic [WORD_W-1:0] stable_w;
	logic [WORD_W-1:0] diff_w;
	logic              accept;
	logic              all_agree;
	logic              door_agree;
	logic              knob_agree;
	logic              scan;

	assign in_ready = !job_valid_s1 || job_take;
	assign accept   = in_valid && in_ready;
	assign scan     = accept && (mode == MODE_SCAN) && scan_en_q;

	assign pw_l      = port_word[LANES-1:0];
	assign pw_w      = WORD_W'(pw_l);
	assign stable_w  = WORD_W'(lane_stable);
	assign diff_w    = WORD_W'(lane_stable ^ pw_l);
	assign all_agree = &lane_agree;

	always_comb begin
		door_agree = 1'b1;
		knob_agree = 1'b1;
		for (int i = 0; i < HW; i++) begin
			if (door_hist_q[i] != door_level) begin
				door_agree = 1'b0;
			end
			if (knob_hist_q[i] != knob_level) begin
				knob_agree = 1'b0;
			end
		end
	end

	always_comb begin
		lane_ctl.prime  = accept && (mode == MODE_INIT);
		lane_ctl.shift  = scan;
		lane_ctl.commit = scan && all_agree;
	end

	always_comb begin
		job_next.act         = ~pw_w;
		job_next.ev_mask     = '0;
		job_next.door_ev     = 1'b0;
		job_next.door_act    = door_level;
		job_next.stable_port = stable_w;
		job_next.stable_door = door_stable_q;
		job_next.knob_closed = knob_flag_q;
		if (mode == MODE_INIT) begin
			job_next.ev_mask     = report_q & WORD_W'({LANES{1'b1}});
			job_next.door_ev     = 1'b1;
			job_next.stable_port = pw_w;
			job_next.stable_door = door_level;
		end else if (scan_en_q) begin
			if (all_agree) begin
				job_next.ev_mask     = diff_w & enable_q;
				job_next.stable_port = pw_w;
			end
			if (door_agree) begin
				job_next.door_ev     = door_stable_q != door_level;
				job_next.stable_door = door_level;
			end
			if (knob_agree) begin
				job_next.knob_closed = !knob_level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= EVENT_ENABLE_RST;
			report_q <= INIT_REPORT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EVENT_ENABLE: enable_q <= cfg_data;
				CFG_INIT_REPORT:  report_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q     <= 1'b0;
			door_hist_q   <= '0;
			knob_hist_q   <= '0;
			door_stable_q <= 1'b0;
			knob_flag_q   <= 1'b0;
		end else if (accept) begin
			if (mode == MODE_INIT) begin
				scan_en_q     <= 1'b1;
				door_hist_q   <= {HW{door_level}};
				door_stable_q <= door_level;
			end else if (scan_en_q) begin
				door_hist_q   <= HW'({door_hist_q, door_level});
				knob_hist_q   <= HW'({knob_hist_q, knob_level});
				door_stable_q <= job_next.stable_door;
				knob_flag_q   <= job_next.knob_closed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= 1'b1;
		end else if (job_take) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_next;
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

	// A pending word is never dropped before the emitter takes it.
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 && !job_take |=> job_valid_s1)
		else $error("pending word lost before hand-off");

	// Priming and shifting never happen on the same word; commit comes only with a shift.
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(lane_ctl.prime && lane_ctl.shift) && (!lane_ctl.commit || lane_ctl.shift))
		else $error("conflicting lane controls");

endmodule

// ===== rtl/pdes_emit.sv =====
module pdes_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  pdes_pkg::job_t              job,
	output logic                        job_take,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [pdes_pkg::IDX_W-1:0]  bit_index,
	output logic                        active,
	output logic [pdes_pkg::WORD_W-1:0] stable_port,
	output logic                        stable_door,
	output logic                        knob_closed,
	output logic                        last
);
	import pdes_pkg::*;

	logic              busy_q;
	logic [WORD_W-1:0] rem_q;
	job_t              cur_q;
	logic              door_ev_q;

	logic              has_port;
	logic [IDX_W-1:0]  idx;
	logic              out_fire;
	kind_t             k_sel;

	// Lowest pending port bit goes first.
	always_comb begin
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign has_port = |rem_q;
	assign out_fire = out_valid && out_ready;
	assign job_take = job_valid && (!busy_q || (out_fire && last));

	always_comb begin
		if (has_port) begin
			k_sel = KIND_PORT;
		end else if (door_ev_q) begin
			k_sel = KIND_DOOR;
		end else begin
			k_sel = KIND_STATUS;
		end
	end

	assign out_valid   = busy_q;
	assign kind        = k_sel;
	assign bit_index   = has_port ? idx : '0;
	assign active      = has_port ? cur_q.act[idx] : (door_ev_q && cur_q.door_act);
	assign last        = !has_port && !door_ev_q;
	assign stable_port = cur_q.stable_port;
	assign stable_door = cur_q.stable_door;
	assign knob_closed = cur_q.knob_closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rem_q     <= '0;
			door_ev_q <= 1'b0;
		end else if (job_take) begin
			busy_q    <= 1'b1;
			rem_q     <= job.ev_mask;
			door_ev_q <= job.door_ev;
		end else if (out_fire) begin
			if (has_port) begin
				rem_q <= rem_q & (rem_q - WORD_W'(1));
			end else if (door_ev_q) begin
				door_ev_q <= 1'b0;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
	end

	// The status word closes a word's results only after all events are out.
	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> rem_q == '0 && !door_ev_q)
		else $error("status word sent with events pending");

	// Results of one input word continue after any non-final result.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> out_valid)
		else $error("result sequence broken");

	// A sent port event is retired from the pending set.
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && has_port |=> !rem_q[$past(idx)])
		else $error("port event not retired");

endmodule

// ===== rtl/port_debounce_event_scanner.sv =====
// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+------------------------------------------
// in      | input     | in_valid/in_ready   | mode, port_word, door_level, knob_level
// out     | output    | out_valid/out_ready | kind, bit_index, active, stable_port,
//         |           |                     | stable_door, knob_closed, last
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// An input word yields 1 to 18 result words, one per cycle from the serializer while out is ready.
// Debounce state updates on the accept edge; each word is then parked in one
// hand-off register, so the next input word is taken while results still drain.
// Under sustained load, input words are taken as fast as the serializer drains their results.
// Reset is asynchronous, active low, and restores the register defaults.
// A stall on out holds the current result; in stalls once the hand-off register fills.
module port_debounce_event_scanner #(
	parameter int PORT_BITS     = 16,
	parameter int AGREE_SAMPLES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] port_word,
	input  logic        door_level,
	input  logic        knob_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  bit_index,
	output logic        active,
	output logic [15:0] stable_port,
	output logic        stable_door,
	output logic        knob_closed,
	output logic        last
);
	import pdes_pkg::*;

	localparam int LANES = (PORT_BITS < WORD_W) ? PORT_BITS : WORD_W;

	lane_ctl_t        lane_ctl;
	logic [LANES-1:0] lane_agree;
	logic [LANES-1:0] lane_stable;
	logic             job_valid;
	job_t             job;
	logic             job_take;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pdes_lane #(
			.AGREE_SAMPLES(AGREE_SAMPLES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.sample (port_word[g]),
			.agree  (lane_agree[g]),
			.stable (lane_stable[g])
		);
	end

	pdes_merge #(
		.PORT_BITS     (PORT_BITS),
		.AGREE_SAMPLES (AGREE_SAMPLES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.port_word   (port_word),
		.door_level  (door_level),
		.knob_level  (knob_level),
		.lane_ctl    (lane_ctl),
		.lane_agree  (lane_agree),
		.lane_stable (lane_stable),
		.job_valid   (job_valid),
		.job         (job),
		.job_take    (job_take)
	);

	pdes_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job),
		.job_take    (job_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.bit_index   (bit_index),
		.active      (active),
		.stable_port (stable_port),
		.stable_door (stable_door),
		.knob_closed (knob_closed),
		.last        (last)
	);

endmodule

// ===== tb/tb_port_debounce_event_scanner.sv =====
`timescale 1ns / 1ps

module tb_port_debounce_event_scanner;
	import pdes_pkg::*;

	localparam int AGREE      = 3;
	localparam int IDLE_LIMIT = 1000;

	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] word;
		logic              door;
		logic              knob;
	} scan_word_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  idx;
		logic              act;
		logic [WORD_W-1:0] sport;
		logic              sdoor;
		logic              knob;
		logic              last;
	} event_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_EVENT_ENABLE;
	logic [15:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              mode = MODE_INIT;
	logic [15:0]       port_word = '0;
	logic              door_level = 1'b0;
	logic              knob_level = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        kind;
	logic [3:0]        bit_index;
	logic              active;
	logic [15:0]       stable_port;
	logic              stable_door;
	logic              knob_closed;
	logic              last;

	port_debounce_event_scanner i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.port_word   (port_word),
		.door_level  (door_level),
		.knob_level  (knob_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.bit_index   (bit_index),
		.active      (active),
		.stable_port (stable_port),
		.stable_door (stable_door),
		.knob_closed (knob_closed),
		.last        (last)
	);

	scan_word_t  stim_words[$];
	event_word_t expected_events[$];

	// Shadow copy of the debounce state and the two mask registers.
	logic [WORD_W-1:0] en_mask  = EVENT_ENABLE_RST;
	logic [WORD_W-1:0] rep_mask = INIT_REPORT_RST;
	logic [WORD_W-1:0] hist_port [AGREE];
	logic              hist_door [AGREE];
	logic              hist_knob [AGREE];
	logic [WORD_W-1:0] stab_port;
	logic              stab_door;
	logic              knob_flag;
	logic              armed;

	int mismatches, n_checked, n_port_ev, n_door_ev, n_init, n_tick;

	// Persistent targets for the random scan sequences.
	logic [WORD_W-1:0] tgt_port;
	logic              tgt_door, tgt_knob;

	function automatic event_word_t mk_event(kind_t k, logic [IDX_W-1:0] idx, logic act);
		event_word_t r;
		r      = '0;
		r.kind = k;
		r.idx  = idx;
		r.act  = act;
		return r;
	endfunction

	task automatic debounce_step(input scan_word_t w);
		event_word_t evs[$];
		event_word_t r;
		logic        agree;
		logic [WORD_W-1:0] diff;
		if (w.mode == MODE_INIT) begin
			stab_port = w.word;
			stab_door = w.door;
			for (int i = 0; i < AGREE; i++) begin
				hist_port[i] = w.word;
				hist_door[i] = w.door;
			end
			for (int i = 0; i < WORD_W; i++)
				if (rep_mask[i])
					evs.push_back(mk_event(KIND_PORT, i[IDX_W-1:0], ~w.word[i]));
			evs.push_back(mk_event(KIND_DOOR, '0, w.door));
			armed = 1'b1;
		end else if (armed) begin
			for (int i = AGREE - 1; i > 0; i--) begin
				hist_port[i] = hist_port[i-1];
				hist_door[i] = hist_door[i-1];
				hist_knob[i] = hist_knob[i-1];
			end
			hist_port[0] = w.word;
			hist_door[0] = w.door;
			hist_knob[0] = w.knob;

			agree = 1'b1;
			for (int i = 1; i < AGREE; i++)
				if (hist_port[i] != w.word) agree = 1'b0;
			if (agree && stab_port != w.word) begin
				diff = (stab_port ^ w.word) & en_mask;
				for (int i = 0; i < WORD_W; i++)
					if (diff[i])
						evs.push_back(mk_event(KIND_PORT, i[IDX_W-1:0], ~w.word[i]));
				stab_port = w.word;
			end

			agree = 1'b1;
			for (int i = 1; i < AGREE; i++)
				if (hist_door[i] != w.door) agree = 1'b0;
			if (agree) begin
				if (stab_door != w.door)
					evs.push_back(mk_event(KIND_DOOR, '0, w.door));
				stab_door = w.door;
			end

			agree = 1'b1;
			for (int i = 1; i < AGREE; i++)
				if (hist_knob[i] != w.knob) agree = 1'b0;
			if (agree)
				knob_flag = ~w.knob;
		end
		evs.push_back(mk_event(KIND_STATUS, '0, 1'b0));

		// Every word of this item carries the state as it stands after the update.
		foreach (evs[k]) begin
			r       = evs[k];
			r.sport = stab_port;
			r.sdoor = stab_door;
			r.knob  = knob_flag;
			r.last  = (k == evs.size() - 1);
			expected_events.push_back(r);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: bursts of random length with random gaps, plus calm stretches.
	scan_word_t cur_word;
	int         burst_left = 1;
	int         gap_left = 0;
	int         tx_cycle = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			tx_cycle++;
			if (in_valid && in_ready) begin
				debounce_step(cur_word);
				if (cur_word.mode == MODE_INIT) n_init++;
				else n_tick++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stim_words.size() > 0) begin
					cur_word = stim_words.pop_front();
					in_valid   <= 1'b1;
					mode       <= cur_word.mode;
					port_word  <= cur_word.word;
					door_level <= cur_word.door;
					knob_level <= cur_word.knob;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = (tx_cycle % 300 < 80) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted word and drives its own stall pattern.
	event_word_t got, want;
	int          rx_cycle = 0;
	int          rx_stall = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				got.kind  = kind_t'(kind);
				got.idx   = bit_index;
				got.act   = active;
				got.sport = stable_port;
				got.sdoor = stable_door;
				got.knob  = knob_closed;
				got.last  = last;
				n_checked++;
				if (got.kind == KIND_PORT) n_port_ev++;
				if (got.kind == KIND_DOOR) n_door_ev++;
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"[%0t] unexpected word: kind=%0d idx=%0d act=%0b",
							" port=%h door=%0b knob=%0b last=%0b"},
							$realtime, got.kind, got.idx, got.act, got.sport, got.sdoor,
							got.knob, got.last);
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"[%0t] mismatch: exp kind=%0d idx=%0d act=%0b",
								" port=%h door=%0b knob=%0b last=%0b"},
								$realtime, want.kind, want.idx, want.act, want.sport,
								want.sdoor, want.knob, want.last);
							$display({"          got kind=%0d idx=%0d act=%0b",
								" port=%h door=%0b knob=%0b last=%0b"},
								got.kind, got.idx, got.act, got.sport, got.sdoor,
								got.knob, got.last);
						end
					end
				end
			end
			if (rx_cycle % 256 < 64) begin
				out_ready <= 1'b1;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				rx_stall = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] timeout: %0d words still expected", $realtime,
				expected_events.size());
			$display("** port_debounce_event_scanner: FAILED **");
			$finish;
		end
	end

	task automatic add(input logic m, input logic [15:0] w, input logic d, input logic k);
		scan_word_t s;
		s.mode = m;
		s.word = w;
		s.door = d;
		s.knob = k;
		stim_words.push_back(s);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (stim_words.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_EVENT_ENABLE) en_mask = val;
		else rep_mask = val;
	endtask

	// Mostly runs of repeated samples so the debounce settles, with glitches
	// and an occasional fresh init thrown in.
	task automatic gen_random(input int n);
		logic [15:0] w;
		logic        d, k;
		for (int j = 0; j < n; j++) begin
			if ($urandom_range(0, 99) < 4) begin
				add(MODE_INIT, 16'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				if ($urandom_range(0, 99) < 25) begin
					if ($urandom_range(0, 1))
						tgt_port = 16'($urandom);
					else
						tgt_port = tgt_port ^ (16'h0001 << $urandom_range(0, 15))
							^ (16'h0001 << $urandom_range(0, 15));
				end
				if ($urandom_range(0, 99) < 20) tgt_door = ~tgt_door;
				if ($urandom_range(0, 99) < 20) tgt_knob = ~tgt_knob;
				w = tgt_port;
				d = tgt_door;
				k = tgt_knob;
				if ($urandom_range(0, 99) < 8) w = w ^ (16'h0001 << $urandom_range(0, 15));
				if ($urandom_range(0, 99) < 5) d = ~d;
				if ($urandom_range(0, 99) < 5) k = ~k;
				add(MODE_SCAN, w, d, k);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < AGREE; i++) begin
			hist_port[i] = '0;
			hist_door[i] = 1'b0;
			hist_knob[i] = 1'b0;
		end
		stab_port = '0;
		stab_door = 1'b0;
		knob_flag = 1'b0;
		armed     = 1'b0;
		tgt_port  = 16'hFFFF;
		tgt_door  = 1'b0;
		tgt_knob  = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Ticks before init leave the state alone.
		add(MODE_SCAN, 16'hA5A5, 1'b1, 1'b0);
		add(MODE_SCAN, 16'h0000, 1'b0, 1'b0);
		// Init twice in a row; the knob is ignored by init.
		add(MODE_INIT, 16'h0000, 1'b0, 1'b1);
		add(MODE_INIT, 16'hFFFF, 1'b1, 1'b0);
		// Full-word settle toward both extremes.
		repeat (3) add(MODE_SCAN, 16'h0000, 1'b0, 1'b0);
		repeat (3) add(MODE_SCAN, 16'hFFFF, 1'b1, 1'b1);
		// A glitch breaks the agreement and restarts the count.
		add(MODE_SCAN, 16'h0F0F, 1'b0, 1'b0);
		add(MODE_SCAN, 16'hFFFF, 1'b1, 1'b1);
		repeat (3) add(MODE_SCAN, 16'h0F0F, 1'b0, 1'b0);
		// Re-init in the middle of scanning.
		add(MODE_INIT, 16'h1234, 1'b0, 1'b1);
		repeat (3) add(MODE_SCAN, 16'h8001, 1'b1, 1'b1);
		gen_random(70);
		wait_idle();

		write_reg(CFG_EVENT_ENABLE, 16'hFFFF);
		write_reg(CFG_INIT_REPORT, 16'hFFFF);
		@(negedge clk);
		add(MODE_INIT, 16'h0000, 1'b1, 1'b0);
		gen_random(75);
		wait_idle();

		write_reg(CFG_EVENT_ENABLE, 16'h0000);
		write_reg(CFG_INIT_REPORT, 16'h0000);
		@(negedge clk);
		add(MODE_INIT, 16'hFFFF, 1'b0, 1'b1);
		gen_random(75);
		wait_idle();

		for (int p = 0; p < 2; p++) begin
			write_reg(CFG_EVENT_ENABLE, 16'($urandom));
			write_reg(CFG_INIT_REPORT, 16'($urandom));
			@(negedge clk);
			gen_random(75);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d init and %0d scan words through several mask settings;",
			n_init, n_tick);
		$display("checked %0d result words (%0d port events, %0d door events), %0d mismatches.",
			n_checked, n_port_ev, n_door_ev, mismatches);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("** port_debounce_event_scanner: PASSED **");
		else
			$display("** port_debounce_event_scanner: FAILED **");
		$finish;
	end

endmodule
